>>> src/stable_sorted_priority_queue_top_assert.svh
// Assertion macros for the sorted priority queue.
// Depends on nothing; included by the top level only.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset
`define SSPQ_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset
`define SSPQ_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define SSPQ_ASSERT(name, clk, rst, prop, msg)
`define SSPQ_NEVER(name, clk, rst, cond, msg)

`endif

`endif

>>> src/sspq_pkg.sv
// Types and codes shared by the sorted priority queue top level and its testbench.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sspq_pkg;

   localparam int KEY_W  = 32;
   localparam int PRIO_W = 32;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   // Operation codes on req_func
   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   // Result status codes
   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   // One stored entry as held in the RAM
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ENQ_CMP,
      ST_ENQ_PUT,
      ST_DEQ
   } state_type;

endpackage

`default_nettype wire

>>> src/sspq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module sspq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/stable_sorted_priority_queue_top.sv
// Top level of the stable sorted priority queue.
// Depends on sspq_pkg, sspq_ram and stable_sorted_priority_queue_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stable_sorted_priority_queue_top_assert.svh"

// Usage
//   A request beat is taken at a rising edge with start high and busy low.
//   req_func selects enqueue (key and priority) or dequeue of the entry with
//   the smallest priority; equal priorities leave in arrival order.
//   Each request gives one result beat: rsp_valid is high for one cycle with
//   status, the removed key and priority (zero unless a dequeue succeeded)
//   and the occupancy after the operation. The receiver cannot stall.
//   Entries sit in one RAM (registered read port) as a circular buffer.
//   Steps from the accepting edge to the result beat:
//     dequeue of an empty queue, enqueue into a full or empty queue: result at once
//     dequeue: one RAM read of the head entry, then the result
//     enqueue: stored entries are compared, walking from the
//       tail one RAM read a cycle and moving each larger one up a place;
//       one more step writes the new entry when it lands at the front.
//   busy is high from the cycle after acceptance until the result cycle, so a
//   new request may be taken in the cycle its predecessor's result is shown.
//   Reset empties the queue; RAM contents are not cleared and need no pass.
module stable_sorted_priority_queue_top #(
   parameter int CAPACITY = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_func,
   input  wire logic signed [sspq_pkg::KEY_W-1:0]  req_entry_key,
   input  wire logic signed [sspq_pkg::PRIO_W-1:0] req_entry_priority,
   output logic                                    rsp_valid,
   output logic        [sspq_pkg::STAT_W-1:0]      rsp_status,
   output logic signed [sspq_pkg::KEY_W-1:0]       rsp_out_key,
   output logic signed [sspq_pkg::PRIO_W-1:0]      rsp_out_priority,
   output logic        [sspq_pkg::OCC_W-1:0]       rsp_occupancy
);

   import sspq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = $bits(entry_type);
   localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

   // Circular index step with wrap at CAPACITY
   function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
      return (i == LAST_IDX) ? '0 : i + AW'(1);
   endfunction

   function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
      return (i == '0) ? LAST_IDX : i - AW'(1);
   endfunction

   state_type           state_ff, state_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [AW-1:0]       tail_ff, tail_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       hole_ff, hole_in;
   logic [AW-1:0]       scan_ff, scan_in;
   logic [CW-1:0]       left_ff, left_in;
   entry_type           pend_ff, pend_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic [PRIO_W-1:0]   rsp_prio_ff, rsp_prio_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   entry_type           ram_wr_entry;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [EW-1:0]       ram_rd_data;
   entry_type           rd_entry;
   logic                accept;

   assign rd_entry = entry_type'(ram_rd_data);
   assign accept   = start && (state_ff == ST_IDLE);

   // Entry store
   sspq_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (EW'(ram_wr_entry)),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hole_ff       <= hole_in;
      scan_ff       <= scan_in;
      left_ff       <= left_in;
      pend_ff       <= pend_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // Next state, RAM accesses and result beat
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      hole_in       = hole_ff;
      scan_in       = scan_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STAT_DONE;
      rsp_key_in    = '0;
      rsp_prio_in   = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hole_ff;
      ram_wr_entry  = pend_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = scan_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_in.key  = req_entry_key;
               pend_in.prio = req_entry_priority;
               if (req_func == FUNC_DEQ) begin
                  if (count_ff == '0) begin
                     // Empty: report at once
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_EMPTY;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = head_ff;
                     state_in    = ST_DEQ;
                  end
               end else if (count_ff == FULL_CNT) begin
                  // Full: drop the entry
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STAT_FULL;
               end else if (count_ff == '0) begin
                  // Empty: write straight at the tail
                  ram_wr_en          = 1'b1;
                  ram_wr_addr        = tail_ff;
                  ram_wr_entry.key   = req_entry_key;
                  ram_wr_entry.prio  = req_entry_priority;
                  tail_in            = idx_inc(tail_ff);
                  count_in           = count_ff + CW'(1);
                  rsp_valid_in       = 1'b1;
               end else begin
                  // Start walking back from the last stored entry
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_dec(tail_ff);
                  hole_in     = tail_ff;
                  scan_in     = idx_dec(tail_ff);
                  left_in     = count_ff;
                  state_in    = ST_ENQ_CMP;
               end
            end
         end

         ST_ENQ_CMP: begin
            if ($signed(rd_entry.prio) > $signed(pend_ff.prio)) begin
               // Move the larger entry up into the hole
               ram_wr_en    = 1'b1;
               ram_wr_addr  = hole_ff;
               ram_wr_entry = rd_entry;
               hole_in      = scan_ff;
               left_in      = left_ff - CW'(1);
               if (left_ff == CW'(1)) begin
                  state_in = ST_ENQ_PUT;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_dec(scan_ff);
                  scan_in     = idx_dec(scan_ff);
               end
            end else begin
               // Found the place: drop the new entry into the hole
               ram_wr_en    = 1'b1;
               ram_wr_addr  = hole_ff;
               tail_in      = idx_inc(tail_ff);
               count_in     = count_ff + CW'(1);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_ENQ_PUT: begin
            // New entry goes to the front
            ram_wr_en    = 1'b1;
            ram_wr_addr  = hole_ff;
            tail_in      = idx_inc(tail_ff);
            count_in     = count_ff + CW'(1);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         ST_DEQ: begin
            // Head entry is on the read port: hand it out and advance
            rsp_valid_in = 1'b1;
            rsp_key_in   = rd_entry.key;
            rsp_prio_in  = rd_entry.prio;
            head_in      = idx_inc(head_ff);
            count_in     = count_ff - CW'(1);
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_occ_in = OCC_W'(count_in);
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_key      = rsp_key_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_occupancy    = rsp_occ_ff;

   // Checks on occupancy bookkeeping and the insertion walk
   `SSPQ_NEVER(a_count_bound, clock, reset, count_ff > FULL_CNT, "count above capacity")
   `SSPQ_NEVER(a_busy_nonempty, clock, reset, busy && (count_ff == '0), "busy on empty store")
   `SSPQ_NEVER(a_walk_left, clock, reset, (state_ff == ST_ENQ_CMP) && (left_ff == '0), "walk past head")
   `SSPQ_ASSERT(a_full_occ, clock, reset, (rsp_valid && (rsp_status == STAT_FULL)) |-> (rsp_occupancy == OCC_W'(CAPACITY)), "full beat with wrong occupancy")
   `SSPQ_ASSERT(a_deq_shrinks, clock, reset, (state_ff == ST_DEQ) |=> (count_ff == $past(count_ff) - CW'(1)), "dequeue did not shrink count")

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the stable sorted priority queue.
// Depends on sspq_pkg and stable_sorted_priority_queue_top; runs directed then random traffic.
`timescale 1ns / 1ps

module testbench;
   import sspq_pkg::*;

   localparam int QUEUE_DEPTH   = 16;
   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_ITEMS  = 1250;
   // longest enqueue walks every stored entry plus the front move
   localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;
   localparam int RUN_LIMIT_NS  = 5_000_000;

   // One expected result beat
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [KEY_W-1:0]  key;
      logic [PRIO_W-1:0] prio;
      logic [OCC_W-1:0]  occupancy;
   } result_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_func;
   logic signed [KEY_W-1:0]  req_entry_key;
   logic signed [PRIO_W-1:0] req_entry_priority;
   logic                     rsp_valid;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [KEY_W-1:0]  rsp_out_key;
   logic signed [PRIO_W-1:0] rsp_out_priority;
   logic [OCC_W-1:0]         rsp_occupancy;

   // Predicted contents of the queue, front at index zero
   entry_type  queued_entries [QUEUE_DEPTH];
   int         queued_count;
   result_type awaited_results [$];
   int         error_count;

   stable_sorted_priority_queue_top #(
      .CAPACITY(QUEUE_DEPTH)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_func           (req_func),
      .req_entry_key      (req_entry_key),
      .req_entry_priority (req_entry_priority),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_out_key        (rsp_out_key),
      .rsp_out_priority   (rsp_out_priority),
      .rsp_occupancy      (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Apply one operation to the predicted queue and return the result it gives
   function automatic result_type predict_queue_op(input logic func, input logic [KEY_W-1:0] key,
                                                   input logic [PRIO_W-1:0] prio);
      result_type outcome;
      int         slot;
      int         idx;
      outcome        = '0;
      outcome.status = STAT_DONE;
      if (func == FUNC_ENQ) begin
         if (queued_count >= QUEUE_DEPTH) begin
            outcome.status = STAT_FULL;
         end else begin
            // place behind every entry of lower or equal priority
            slot = 0;
            while (slot < queued_count && $signed(queued_entries[slot].prio) <= $signed(prio))
               slot++;
            for (idx = queued_count; idx > slot; idx--)
               queued_entries[idx] = queued_entries[idx - 1];
            queued_entries[slot].key  = key;
            queued_entries[slot].prio = prio;
            queued_count++;
         end
      end else begin
         if (queued_count == 0) begin
            outcome.status = STAT_EMPTY;
         end else begin
            outcome.key  = queued_entries[0].key;
            outcome.prio = queued_entries[0].prio;
            for (idx = 1; idx < queued_count; idx++)
               queued_entries[idx - 1] = queued_entries[idx];
            queued_count--;
         end
      end
      outcome.occupancy = queued_count[OCC_W-1:0];
      return outcome;
   endfunction

   // Drive one request beat and hold it until busy is low at a rising edge
   task automatic send_request(input logic func, input logic [KEY_W-1:0] key,
                               input logic [PRIO_W-1:0] prio);
      @(negedge clock);
      start              <= 1'b1;
      req_func           <= func;
      req_entry_key      <= key;
      req_entry_priority <= prio;
      @(posedge clock);
      while (busy) @(posedge clock);
      awaited_results.push_back(predict_queue_op(func, key, prio));
   endtask

   // Drop start for a number of cycles, with junk on the request fields
   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start              <= 1'b0;
         req_func           <= 1'($urandom_range(0, 1));
         req_entry_key      <= $urandom();
         req_entry_priority <= $urandom();
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Mostly no gap, some short ones, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Clustered values give plenty of ties; the rest span the full range
   function automatic logic [PRIO_W-1:0] pick_priority();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         return $urandom_range(0, 6) - 3;
      else if (roll < 50) begin
         case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
         endcase
      end else
         return $urandom();
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 'h%h, got 'h%h", name, want, got);
         error_count++;
      end
   endtask

   // Compare each result beat with the oldest outstanding prediction
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            $error("result beat with no request outstanding");
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("rsp_status", 32'(want.status), 32'(rsp_status));
            check_field("rsp_out_key", want.key, rsp_out_key);
            check_field("rsp_out_priority", want.prio, rsp_out_priority);
            check_field("rsp_occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
         end
      end
   end

   // Dequeue straight after reset must report an empty queue
   task automatic test_empty_dequeue();
      send_request(FUNC_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // Fill with extreme and tied priorities, then push once more into the full store
   task automatic test_fill_and_overflow();
      int idx;
      send_request(FUNC_ENQ, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(FUNC_ENQ, 32'h8000_0000, 32'h8000_0000);
      send_request(FUNC_ENQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_ENQ, 32'h0000_0000, 32'h0000_0000);
      for (idx = 4; idx < QUEUE_DEPTH; idx++)
         send_request(FUNC_ENQ, idx, (idx % 3 == 0) ? 32'h7FFF_FFFF : 32'h0000_0000);
      send_request(FUNC_ENQ, 32'h5555_5555, 32'h8000_0000);
   endtask

   // Take a few entries off the front; ties must come out in arrival order
   task automatic test_drain_front();
      repeat (4) send_request(FUNC_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   // Bursts biased towards filling, draining or balance, with random pacing
   task automatic test_random_traffic();
      int   sent;
      int   burst_len;
      int   enq_share;
      bit   gapless;
      logic func;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(4, 40);
         case ($urandom_range(0, 3))
            0:       enq_share = 85;
            1:       enq_share = 15;
            default: enq_share = 50;
         endcase
         gapless = ($urandom_range(0, 3) == 0);
         repeat (burst_len) begin
            func = ($urandom_range(0, 99) < enq_share) ? FUNC_ENQ : FUNC_DEQ;
            send_request(func, $urandom(), pick_priority());
            if (!gapless) hold_off(pick_gap());
            sent++;
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_func           = FUNC_ENQ;
      req_entry_key      = '0;
      req_entry_priority = '0;
      queued_count       = 0;
      error_count        = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_dequeue();
      test_fill_and_overflow();
      test_drain_front();
      test_random_traffic();

      // Release the request line and let the last results come back
      @(negedge clock);
      start <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Stop a hung run
   initial begin
      #(RUN_LIMIT_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
